[rtl/clp_pkg.sv]
// Shared types and constants of the triangle plane clipper.
// Used by the top level, the port checker and the testbench; depends on nothing.
package clp_pkg;

    localparam int unsigned COLOR_WIDTH   = 32;
    localparam int unsigned CFG_IDX_WIDTH = 3;
    localparam int unsigned STEP_WIDTH    = 3;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_WIDTH-1:0] {
        REG_NORMAL_X = 3'd0,
        REG_NORMAL_Y = 3'd1,
        REG_NORMAL_Z = 3'd2,
        REG_PLANE_X  = 3'd3,
        REG_PLANE_Y  = 3'd4,
        REG_PLANE_Z  = 3'd5
    } t_cfg_reg;

    // How many vertices of a triangle lie on the kept side of the plane
    typedef enum logic [1:0] {
        KIND_NONE = 2'd0,
        KIND_ONE  = 2'd1,
        KIND_TWO  = 2'd2,
        KIND_ALL  = 2'd3
    } t_kind;

    // Slots of the vertex roles: first inside, second, remaining
    localparam logic [1:0] SLOT_A = 2'd0;
    localparam logic [1:0] SLOT_B = 2'd1;
    localparam logic [1:0] SLOT_C = 2'd2;

    // Output steps that close a triangle, and the step that opens the second one
    localparam logic [STEP_WIDTH-1:0] STEP_TRI0_END = 3'd2;
    localparam logic [STEP_WIDTH-1:0] STEP_TRI1_END = 3'd5;
    localparam logic [STEP_WIDTH-1:0] STEP_SECOND   = 3'd3;

    typedef struct packed {
        t_kind      kind;
        logic [1:0] ia;
        logic [1:0] ib;
        logic [1:0] ic;
    } t_sel;

    // Map the inside mask (bit k set: vertex k inside) to the vertex roles.
    // One inside: ia inside, ib/ic outside. Two inside: ia/ib inside, ic outside.
    function automatic t_sel classify(input logic [2:0] ins);
        t_sel s;
        unique case (ins)
            3'b000:  s = '{KIND_NONE, 2'd0, 2'd1, 2'd2};
            3'b001:  s = '{KIND_ONE,  2'd0, 2'd1, 2'd2};
            3'b010:  s = '{KIND_ONE,  2'd1, 2'd0, 2'd2};
            3'b100:  s = '{KIND_ONE,  2'd2, 2'd0, 2'd1};
            3'b011:  s = '{KIND_TWO,  2'd0, 2'd1, 2'd2};
            3'b101:  s = '{KIND_TWO,  2'd0, 2'd2, 2'd1};
            3'b110:  s = '{KIND_TWO,  2'd1, 2'd2, 2'd0};
            3'b111:  s = '{KIND_ALL,  2'd0, 2'd1, 2'd2};
            default: s = '{KIND_NONE, 2'd0, 2'd1, 2'd2};
        endcase
        return s;
    endfunction

endpackage

[rtl/triangle_plane_clipper.sv]
// Triangle clipper against one configurable plane (top level).
// Depends on clp_pkg and instantiates clp_div.
//
// Usage: a triangle (three Q16.16 vertices with colors) enters through a
// valid/stall channel and may enter in every cycle while o_stall is low.
// Distances to the plane and intersection points are computed in a pipeline
// of 9 + COORD_WIDTH + 1 register stages (42 at the default width); the long
// part is the divider, which resolves one quotient bit per stage. Results
// leave one vertex per cycle from an output stage while i_stall is low: three
// for a triangle fully inside or with one vertex inside, six for one with two
// inside; a triangle fully outside produces nothing. The output port therefore
// bounds the sustained rate. Plane registers are written through a plain write
// port only while idle; the user is bound by this, the block does not enforce it.
module triangle_plane_clipper #(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic signed [COORD_WIDTH-1:0]        i_v0_x,
    input  logic signed [COORD_WIDTH-1:0]        i_v0_y,
    input  logic signed [COORD_WIDTH-1:0]        i_v0_z,
    input  logic [clp_pkg::COLOR_WIDTH-1:0]      i_v0_color,
    input  logic signed [COORD_WIDTH-1:0]        i_v1_x,
    input  logic signed [COORD_WIDTH-1:0]        i_v1_y,
    input  logic signed [COORD_WIDTH-1:0]        i_v1_z,
    input  logic [clp_pkg::COLOR_WIDTH-1:0]      i_v1_color,
    input  logic signed [COORD_WIDTH-1:0]        i_v2_x,
    input  logic signed [COORD_WIDTH-1:0]        i_v2_y,
    input  logic signed [COORD_WIDTH-1:0]        i_v2_z,
    input  logic [clp_pkg::COLOR_WIDTH-1:0]      i_v2_color,
    input  logic                                 i_cfg_we,
    input  logic [clp_pkg::CFG_IDX_WIDTH-1:0]    i_cfg_idx,
    input  logic [COORD_WIDTH-1:0]               i_cfg_data,
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic signed [COORD_WIDTH-1:0]        o_out_x,
    output logic signed [COORD_WIDTH-1:0]        o_out_y,
    output logic signed [COORD_WIDTH-1:0]        o_out_z,
    output logic [clp_pkg::COLOR_WIDTH-1:0]      o_out_color,
    output logic                                 o_end_of_triangle,
    output logic                                 o_last
);

    import clp_pkg::*;

    localparam int W   = COORD_WIDTH;
    localparam int DIF = W + 1;
    localparam int PRD = 2 * W + 1;
    localparam int DST = 2 * W + 3;
    localparam int DS  = 2 * W + 2;
    localparam int DEN = 2 * W + 3;
    localparam int MAG = W + 1;
    localparam int HW  = W + 1;
    localparam int PP  = 2 * HW;
    localparam int NUM = 3 * W + 3;
    localparam int QW  = W + 1;
    localparam int SUM = W + 2;

    typedef struct packed {
        t_kind                  kind;
        logic [1:0][2:0]        neg;
        logic [2:0][2:0][W-1:0] pos;
        logic [2:0][COLOR_WIDTH-1:0] col;
    } t_meta;

    // ---------------- configuration ----------------
    logic signed [W-1:0] r_nrm [3];
    logic signed [W-1:0] r_pnt [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nrm[0] <= '0;
            r_nrm[1] <= '0;
            r_nrm[2] <= W'(1) << FRAC_BITS;
            r_pnt[0] <= '0;
            r_pnt[1] <= '0;
            r_pnt[2] <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_idx))
                REG_NORMAL_X: r_nrm[0] <= i_cfg_data;
                REG_NORMAL_Y: r_nrm[1] <= i_cfg_data;
                REG_NORMAL_Z: r_nrm[2] <= i_cfg_data;
                REG_PLANE_X:  r_pnt[0] <= i_cfg_data;
                REG_PLANE_Y:  r_pnt[1] <= i_cfg_data;
                REG_PLANE_Z:  r_pnt[2] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ---------------- flow control ----------------
    logic w_en;
    logic w_ser_free;
    logic w_ser_end;

    logic r1_v, r2_v, r3_v, r4_v, r5_v, r6_v, r7_v, r8_v, r9_v;
    logic r_dv [QW];

    assign w_en    = !r9_v || w_ser_free;
    assign o_stall = !w_en || !i_rst_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
            r5_v <= 1'b0;
            r6_v <= 1'b0;
            r7_v <= 1'b0;
            r8_v <= 1'b0;
            r9_v <= 1'b0;
            for (int i = 0; i < QW; i++) r_dv[i] <= 1'b0;
        end else if (w_en) begin
            r1_v <= i_valid;
            r2_v <= r1_v;
            r3_v <= r2_v;
            r4_v <= r3_v;
            r5_v <= r4_v;
            r6_v <= r5_v;
            r7_v <= r6_v;
            r_dv[0] <= r7_v;
            for (int i = 1; i < QW; i++) r_dv[i] <= r_dv[i-1];
            r8_v <= r_dv[QW-1];
            r9_v <= r8_v;
        end
    end

    // ---------------- stage 1: capture, offset from plane point ----------------
    logic signed [W-1:0]   w_in_pos [3][3];
    logic [COLOR_WIDTH-1:0] w_in_col [3];

    assign w_in_pos[0][0] = i_v0_x;
    assign w_in_pos[0][1] = i_v0_y;
    assign w_in_pos[0][2] = i_v0_z;
    assign w_in_pos[1][0] = i_v1_x;
    assign w_in_pos[1][1] = i_v1_y;
    assign w_in_pos[1][2] = i_v1_z;
    assign w_in_pos[2][0] = i_v2_x;
    assign w_in_pos[2][1] = i_v2_y;
    assign w_in_pos[2][2] = i_v2_z;
    assign w_in_col[0]    = i_v0_color;
    assign w_in_col[1]    = i_v1_color;
    assign w_in_col[2]    = i_v2_color;

    logic signed [W-1:0]    r1_pos [3][3];
    logic [COLOR_WIDTH-1:0] r1_col [3];
    logic signed [DIF-1:0]  r1_dif [3][3];
    logic signed [W-1:0]    r2_pos [3][3];
    logic [COLOR_WIDTH-1:0] r2_col [3];
    logic signed [PRD-1:0]  r2_prd [3][3];
    logic signed [W-1:0]    r3_pos [3][3];
    logic [COLOR_WIDTH-1:0] r3_col [3];
    logic signed [DST-1:0]  r3_dst [3];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int v = 0; v < 3; v++) begin
                r1_col[v] <= w_in_col[v];
                r2_col[v] <= r1_col[v];
                r3_col[v] <= r2_col[v];
                r3_dst[v] <= DST'(r2_prd[v][0]) + DST'(r2_prd[v][1]) + DST'(r2_prd[v][2]);
                for (int c = 0; c < 3; c++) begin
                    r1_pos[v][c] <= w_in_pos[v][c];
                    r1_dif[v][c] <= DIF'(w_in_pos[v][c]) - DIF'(r_pnt[c]);
                    r2_pos[v][c] <= r1_pos[v][c];
                    r2_prd[v][c] <= PRD'(r_nrm[c]) * PRD'(r1_dif[v][c]);
                    r3_pos[v][c] <= r2_pos[v][c];
                end
            end
        end
    end

    // ---------------- stage 4: classify, pick edges ----------------
    t_meta               n4_meta;
    logic [DS-1:0]       n4_ds  [2];
    logic [DEN-1:0]      n4_den [2];
    logic signed [DIF-1:0] n4_dlt [2][3];

    always_comb begin
        logic [2:0] ins;
        t_sel       sel;
        logic [1:0] si [2];
        logic [1:0] ei [2];
        for (int v = 0; v < 3; v++) ins[v] = ~r3_dst[v][DST-1];
        sel   = classify(ins);
        si[0] = sel.ia;
        ei[0] = (sel.kind == KIND_ONE) ? sel.ib : sel.ic;
        si[1] = (sel.kind == KIND_ONE) ? sel.ia : sel.ib;
        ei[1] = sel.ic;
        for (int j = 0; j < 2; j++) begin
            n4_ds[j]  = r3_dst[si[j]][DS-1:0];
            n4_den[j] = DEN'(r3_dst[si[j]] - r3_dst[ei[j]]);
            for (int c = 0; c < 3; c++) begin
                n4_dlt[j][c] = DIF'(r3_pos[ei[j]][c]) - DIF'(r3_pos[si[j]][c]);
            end
        end
        n4_meta.kind = sel.kind;
        n4_meta.neg  = '0;
        for (int c = 0; c < 3; c++) begin
            n4_meta.pos[SLOT_A][c] = r3_pos[sel.ia][c];
            n4_meta.pos[SLOT_B][c] = r3_pos[sel.ib][c];
            n4_meta.pos[SLOT_C][c] = r3_pos[sel.ic][c];
        end
        n4_meta.col[SLOT_A] = r3_col[sel.ia];
        n4_meta.col[SLOT_B] = r3_col[sel.ib];
        n4_meta.col[SLOT_C] = r3_col[sel.ic];
    end

    t_meta                 r4_meta, r5_meta, r6_meta, r7_meta, r8_meta, r9_meta;
    t_meta                 r_dmeta [QW];
    logic [DS-1:0]         r4_ds  [2];
    logic [DEN-1:0]        r4_den [2];
    logic signed [DIF-1:0] r4_dlt [2][3];
    logic [DS-1:0]         r5_ds  [2];
    logic [DEN-1:0]        r5_den [2];
    logic [MAG-1:0]        r5_mag [2][3];
    logic [DEN-1:0]        r6_den [2];
    logic [PP-1:0]         r6_pl  [2][3];
    logic [PP-1:0]         r6_ph  [2][3];
    logic [DEN-1:0]        r7_den [2];
    logic [NUM-1:0]        r7_num [2][3];
    logic signed [SUM-1:0] r8_sq  [2][3];
    logic [2:0][W-1:0]     r9_x   [2];

    logic [NUM-1:0] w_dnum [6];
    logic [DEN-1:0] w_dden [6];
    logic [QW-1:0]  w_dquo [6];

    // stage 5 metadata: record the sign of each edge delta
    t_meta n5_meta;

    always_comb begin
        n5_meta = r4_meta;
        for (int j = 0; j < 2; j++) begin
            for (int c = 0; c < 3; c++) begin
                n5_meta.neg[j][c] = r4_dlt[j][c][DIF-1];
            end
        end
    end

    always_comb begin
        for (int j = 0; j < 2; j++) begin
            for (int c = 0; c < 3; c++) begin
                w_dnum[j*3+c] = r7_num[j][c];
                w_dden[j*3+c] = r7_den[j];
            end
        end
    end

    clp_div #(
        .NUM_W (NUM),
        .DEN_W (DEN),
        .QUO_W (QW),
        .LANES (6)
    ) u_clp_div (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_num (w_dnum),
        .i_den (w_dden),
        .o_quo (w_dquo)
    );

    // stage 9 combinational: add offset to edge start, saturate
    logic [2:0][W-1:0] n9_x [2];

    always_comb begin
        logic signed [SUM-1:0] sum;
        logic [W-1:0]          start;
        for (int j = 0; j < 2; j++) begin
            for (int c = 0; c < 3; c++) begin
                start = (j == 0 || r8_meta.kind == KIND_ONE) ? r8_meta.pos[SLOT_A][c]
                                                             : r8_meta.pos[SLOT_B][c];
                sum = SUM'($signed(start)) + r8_sq[j][c];
                if (sum[SUM-1:W-1] != {(SUM-W+1){sum[SUM-1]}}) begin
                    n9_x[j][c] = {sum[SUM-1], {(W-1){~sum[SUM-1]}}};
                end else begin
                    n9_x[j][c] = sum[W-1:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r4_meta <= n4_meta;
            r5_meta <= n5_meta;
            for (int j = 0; j < 2; j++) begin
                r4_ds[j]  <= n4_ds[j];
                r4_den[j] <= n4_den[j];
                r5_ds[j]  <= r4_ds[j];
                r5_den[j] <= r4_den[j];
                r6_den[j] <= r5_den[j];
                r7_den[j] <= r6_den[j];
                r9_x[j]   <= n9_x[j];
                for (int c = 0; c < 3; c++) begin
                    r4_dlt[j][c]      <= n4_dlt[j][c];
                    r5_mag[j][c]      <= r4_dlt[j][c][DIF-1] ? MAG'(-r4_dlt[j][c])
                                                             : MAG'(r4_dlt[j][c]);
                    // split the wide distance into two narrow products
                    r6_pl[j][c] <= PP'(r5_mag[j][c]) * PP'(r5_ds[j][HW-1:0]);
                    r6_ph[j][c] <= PP'(r5_mag[j][c]) * PP'(r5_ds[j][DS-1:HW]);
                    r7_num[j][c] <= (NUM'(r6_ph[j][c]) << HW) + NUM'(r6_pl[j][c]);
                    r8_sq[j][c]  <= r_dmeta[QW-1].neg[j][c]
                                    ? -$signed(SUM'(w_dquo[j*3+c]))
                                    :  $signed(SUM'(w_dquo[j*3+c]));
                end
            end
            r6_meta    <= r5_meta;
            r7_meta    <= r6_meta;
            r_dmeta[0] <= r7_meta;
            for (int i = 1; i < QW; i++) r_dmeta[i] <= r_dmeta[i-1];
            r8_meta <= r_dmeta[QW-1];
            r9_meta <= r8_meta;
        end
    end

    // ---------------- output sequencer ----------------
    logic                  r_sv;
    logic [STEP_WIDTH-1:0] r_step;
    t_meta                 r_smeta;
    logic [2:0][W-1:0]     r_sx [2];

    assign w_ser_end  = (r_smeta.kind == KIND_TWO) ? (r_step == STEP_TRI1_END)
                                                   : (r_step == STEP_TRI0_END);
    assign w_ser_free = !r_sv || (w_ser_end && !i_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sv   <= 1'b0;
            r_step <= '0;
        end else if (w_ser_free) begin
            // drop triangles that lie fully outside
            r_sv   <= r9_v && (r9_meta.kind != KIND_NONE);
            r_step <= '0;
        end else if (!i_stall) begin
            r_step <= r_step + STEP_WIDTH'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ser_free) begin
            r_smeta <= r9_meta;
            r_sx[0] <= r9_x[0];
            r_sx[1] <= r9_x[1];
        end
    end

    logic [2:0][W-1:0] w_opos;
    logic [1:0]        w_cslot;

    always_comb begin
        w_cslot = (r_step < STEP_SECOND) ? r_step[1:0] : 2'(r_step - STEP_SECOND);
        case (r_step)
            3'd0: w_opos = r_smeta.pos[SLOT_A];
            3'd1: w_opos = (r_smeta.kind == KIND_ONE) ? r_sx[0] : r_smeta.pos[SLOT_B];
            3'd2: begin
                if (r_smeta.kind == KIND_ALL) begin
                    w_opos = r_smeta.pos[SLOT_C];
                end else if (r_smeta.kind == KIND_ONE) begin
                    w_opos = r_sx[1];
                end else begin
                    w_opos = r_sx[0];
                end
            end
            3'd3:    w_opos = r_smeta.pos[SLOT_B];
            3'd4:    w_opos = r_sx[1];
            default: w_opos = r_sx[0];
        endcase
    end

    assign o_valid           = r_sv;
    assign o_out_x           = w_opos[0];
    assign o_out_y           = w_opos[1];
    assign o_out_z           = w_opos[2];
    assign o_out_color       = r_smeta.col[w_cslot];
    assign o_end_of_triangle = (r_step == STEP_TRI0_END) || (r_step == STEP_TRI1_END);
    assign o_last            = w_ser_end;

endmodule

[rtl/clp_div.sv]
// Pipelined restoring divider, one quotient bit per stage, several lanes.
// Used by the clipper to place edge-plane intersections; no package needed.
module clp_div #(
    parameter int NUM_W = 99,
    parameter int DEN_W = 67,
    parameter int QUO_W = 33,
    parameter int LANES = 6
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [NUM_W-1:0] i_num [LANES],
    input  logic [DEN_W-1:0] i_den [LANES],
    output logic [QUO_W-1:0] o_quo [LANES]
);

    localparam int CMP_W = DEN_W + QUO_W + 1;

    logic [NUM_W-1:0] r_rem [QUO_W][LANES];
    logic [DEN_W-1:0] r_den [QUO_W][LANES];
    logic [QUO_W-1:0] r_quo [QUO_W][LANES];

    for (genvar g = 0; g < QUO_W; g++) begin : g_stage
        localparam int K = QUO_W - 1 - g;
        logic [NUM_W-1:0] rem_in [LANES];
        logic [DEN_W-1:0] den_in [LANES];
        logic [QUO_W-1:0] quo_in [LANES];
        logic [NUM_W-1:0] n_rem  [LANES];
        logic [QUO_W-1:0] n_quo  [LANES];

        always_comb begin
            for (int l = 0; l < LANES; l++) begin
                if (g == 0) begin
                    rem_in[l] = i_num[l];
                    den_in[l] = i_den[l];
                    quo_in[l] = '0;
                end else begin
                    rem_in[l] = r_rem[(g == 0) ? 0 : g - 1][l];
                    den_in[l] = r_den[(g == 0) ? 0 : g - 1][l];
                    quo_in[l] = r_quo[(g == 0) ? 0 : g - 1][l];
                end
            end
        end

        always_comb begin
            logic [CMP_W-1:0] trial;
            for (int l = 0; l < LANES; l++) begin
                trial = CMP_W'(rem_in[l]) - (CMP_W'(den_in[l]) << K);
                // keep the trial difference when it did not go negative
                if (!trial[CMP_W-1]) begin
                    n_rem[l] = trial[NUM_W-1:0];
                    n_quo[l] = quo_in[l] | (QUO_W'(1) << K);
                end else begin
                    n_rem[l] = rem_in[l];
                    n_quo[l] = quo_in[l];
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                for (int l = 0; l < LANES; l++) begin
                    r_rem[g][l] <= n_rem[l];
                    r_den[g][l] <= den_in[l];
                    r_quo[g][l] <= n_quo[l];
                end
            end
        end
    end

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            o_quo[l] = r_quo[QUO_W-1][l];
        end
    end

endmodule

[rtl/clp_chk.sv]
// Port-level checker for the triangle plane clipper, bound to the top level.
// Depends on clp_pkg for the color width.
module clp_chk #(
    parameter int COORD_WIDTH = 32
) (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_valid,
    input logic                              o_stall,
    input logic                              o_valid,
    input logic                              i_stall,
    input logic signed [COORD_WIDTH-1:0]     o_out_x,
    input logic signed [COORD_WIDTH-1:0]     o_out_y,
    input logic signed [COORD_WIDTH-1:0]     o_out_z,
    input logic [clp_pkg::COLOR_WIDTH-1:0]   o_out_color,
    input logic                              o_end_of_triangle,
    input logic                              o_last
);

    import clp_pkg::*;

    // hold a stalled output transaction
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_out_x) && $stable(o_out_y)
                               && $stable(o_out_z) && $stable(o_out_color)
                               && $stable(o_last) && $stable(o_end_of_triangle))
        else $error("stalled output transaction changed");

    // the final vertex of an input always closes a triangle
    a_last_eot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_last |-> o_end_of_triangle)
        else $error("last vertex without end of triangle");

    // vertices of one input leave without gaps
    a_no_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall && !o_last |=> o_valid && !$past(o_last))
        else $error("gap inside the vertex run of one triangle");

    // reset empties the output and blocks input
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid right after reset");

    a_reset_stall: assert property (@(posedge i_clk)
        !i_rst_n |-> o_stall)
        else $error("input accepted during reset");

endmodule

bind triangle_plane_clipper clp_chk #(
    .COORD_WIDTH (COORD_WIDTH)
) u_clp_chk (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_valid           (i_valid),
    .o_stall           (o_stall),
    .o_valid           (o_valid),
    .i_stall           (i_stall),
    .o_out_x           (o_out_x),
    .o_out_y           (o_out_y),
    .o_out_z           (o_out_z),
    .o_out_color       (o_out_color),
    .o_end_of_triangle (o_end_of_triangle),
    .o_last            (o_last)
);

[tb/sv/tb_triangle_plane_clipper.sv]
// Testbench of triangle_plane_clipper: a directed table of triangles, then random ones.
// A local predictor checks every output vertex; depends on clp_pkg and the clipper RTL.
`timescale 1ns / 1ps
module tb_triangle_plane_clipper;
    import clp_pkg::*;

    localparam int CW         = 32;
    localparam int PIPE_DEPTH = 42;
    localparam int IDLE_LIMIT = 6000;
    localparam logic signed [CW-1:0] CMAX = 32'sh7fffffff;
    localparam logic signed [CW-1:0] CMIN = 32'sh80000000;
    localparam logic signed [CW-1:0] ONE  = 32'sh00010000;
    // indexes past the register list, written to check they are ignored
    localparam logic [CFG_IDX_WIDTH-1:0] IDX_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_WIDTH-1:0] IDX_SPARE_HI = 3'd7;

    typedef enum logic [1:0] { ROW_PREDICT, ROW_PASS, ROW_DROP } t_row_kind;

    typedef struct {
        logic signed [CW-1:0] pos [3];
        logic [COLOR_WIDTH-1:0] color;
    } t_vert;

    typedef struct {
        t_vert v [3];
    } t_tri;

    typedef struct {
        logic signed [CW-1:0] x, y, z;
        logic [COLOR_WIDTH-1:0] color;
        logic eot, last;
    } t_clip_vert;

    typedef struct {
        t_row_kind kind;
        t_tri      t;
    } t_row;

    logic i_clk, i_rst_n, i_valid, o_stall, i_cfg_we, o_valid, i_stall;
    logic signed [CW-1:0] i_v0_x, i_v0_y, i_v0_z, i_v1_x, i_v1_y, i_v1_z;
    logic signed [CW-1:0] i_v2_x, i_v2_y, i_v2_z;
    logic [COLOR_WIDTH-1:0] i_v0_color, i_v1_color, i_v2_color;
    logic [CFG_IDX_WIDTH-1:0] i_cfg_idx;
    logic [CW-1:0] i_cfg_data;
    logic signed [CW-1:0] o_out_x, o_out_y, o_out_z;
    logic [COLOR_WIDTH-1:0] o_out_color;
    logic o_end_of_triangle, o_last;

    triangle_plane_clipper dut (.*);

    logic signed [CW-1:0] plane_regs [6];
    t_clip_vert clip_verts_q [$];
    int fail_count;
    int idle_pct, stall_pct;
    int quiet_cycles;

    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    function automatic logic signed [127:0] plane_dist(t_vert v);
        logic signed [127:0] acc, n, d;
        acc = '0;
        for (int k = 0; k < 3; k++) begin
            n = 128'(plane_regs[k]);
            d = 128'(v.pos[k]);
            d = d - 128'(plane_regs[3 + k]);
            acc = acc + n * d;
        end
        return acc;
    endfunction

    // Edge s (inside) to e (outside): s + trunc((e - s) * ds / (ds - de)), saturated
    function automatic t_vert edge_cross(t_vert s, t_vert e, logic signed [127:0] ds,
                                         logic signed [127:0] de);
        t_vert r;
        logic signed [127:0] den, num, sv, ev, q;
        den = ds - de;
        for (int k = 0; k < 3; k++) begin
            sv = 128'(s.pos[k]);
            ev = 128'(e.pos[k]);
            num = (ev - sv) * ds;
            q = num / den;
            q = sv + q;
            if (q > 128'(CMAX)) q = 128'(CMAX);
            if (q < 128'(CMIN)) q = 128'(CMIN);
            r.pos[k] = q[CW-1:0];
        end
        r.color = '0;
        return r;
    endfunction

    task automatic push_vert(t_vert p, logic [COLOR_WIDTH-1:0] col, logic eot, logic last);
        clip_verts_q.push_back('{p.pos[0], p.pos[1], p.pos[2], col, eot, last});
    endtask

    task automatic predict_clip(t_tri t);
        logic signed [127:0] d [3];
        int ins [$], outs [$];
        int a, b, c;
        t_vert p1, p2;
        for (int k = 0; k < 3; k++) begin
            d[k] = plane_dist(t.v[k]);
            if (d[k] >= 0) ins.push_back(k);
            else outs.push_back(k);
        end
        case (ins.size())
            3: for (int k = 0; k < 3; k++) push_vert(t.v[k], t.v[k].color, k == 2, k == 2);
            1: begin
                a = ins[0]; b = outs[0]; c = outs[1];
                p1 = edge_cross(t.v[a], t.v[b], d[a], d[b]);
                p2 = edge_cross(t.v[a], t.v[c], d[a], d[c]);
                push_vert(t.v[a], t.v[a].color, 1'b0, 1'b0);
                push_vert(p1, t.v[b].color, 1'b0, 1'b0);
                push_vert(p2, t.v[c].color, 1'b1, 1'b1);
            end
            2: begin
                a = ins[0]; b = ins[1]; c = outs[0];
                p1 = edge_cross(t.v[a], t.v[c], d[a], d[c]);
                p2 = edge_cross(t.v[b], t.v[c], d[b], d[c]);
                push_vert(t.v[a], t.v[a].color, 1'b0, 1'b0);
                push_vert(t.v[b], t.v[b].color, 1'b0, 1'b0);
                push_vert(p1, t.v[c].color, 1'b1, 1'b0);
                push_vert(t.v[b], t.v[a].color, 1'b0, 1'b0);
                push_vert(p2, t.v[b].color, 1'b0, 1'b0);
                push_vert(p1, t.v[c].color, 1'b1, 1'b1);
            end
            default: ;
        endcase
    endtask

    task automatic cfg_write(logic [CFG_IDX_WIDTH-1:0] idx, logic [CW-1:0] val);
        i_cfg_we = 1'b1;
        i_cfg_idx = idx;
        i_cfg_data = val;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        if (idx <= REG_PLANE_Z) plane_regs[idx] = val;
    endtask

    task automatic set_plane(logic signed [CW-1:0] nx, ny, nz, px, py, pz);
        cfg_write(REG_NORMAL_X, nx);
        cfg_write(REG_NORMAL_Y, ny);
        cfg_write(REG_NORMAL_Z, nz);
        cfg_write(REG_PLANE_X, px);
        cfg_write(REG_PLANE_Y, py);
        cfg_write(REG_PLANE_Z, pz);
    endtask

    // Hold until every expected vertex is out, then let the pipeline empty
    task automatic drain();
        while (clip_verts_q.size() != 0) @(negedge i_clk);
        repeat (PIPE_DEPTH + 16) @(negedge i_clk);
    endtask

    task automatic send_tri(t_tri t, t_row_kind kind);
        while ($urandom_range(99) < idle_pct) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        {i_v0_x, i_v0_y, i_v0_z, i_v0_color} = {t.v[0].pos[0], t.v[0].pos[1], t.v[0].pos[2],
                                                t.v[0].color};
        {i_v1_x, i_v1_y, i_v1_z, i_v1_color} = {t.v[1].pos[0], t.v[1].pos[1], t.v[1].pos[2],
                                                t.v[1].color};
        {i_v2_x, i_v2_y, i_v2_z, i_v2_color} = {t.v[2].pos[0], t.v[2].pos[1], t.v[2].pos[2],
                                                t.v[2].color};
        i_valid = 1'b1;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        case (kind)
            ROW_PASS: for (int k = 0; k < 3; k++)
                push_vert(t.v[k], t.v[k].color, k == 2, k == 2);
            ROW_DROP: ;
            default: predict_clip(t);
        endcase
        @(negedge i_clk);
    endtask

    function automatic logic signed [CW-1:0] rand_coord();
        case ($urandom_range(3))
            0: return $urandom;
            1, 2: return $signed($urandom_range(2 ** 21)) - (2 ** 20);
            default: case ($urandom_range(3))
                0: return CMAX;
                1: return CMIN;
                2: return 0;
                default: return -1;
            endcase
        endcase
    endfunction

    function automatic t_vert mk_vert(logic signed [CW-1:0] x, y, z, logic [31:0] col);
        t_vert v;
        v.pos[0] = x; v.pos[1] = y; v.pos[2] = z;
        v.color = col;
        return v;
    endfunction

    function automatic t_tri rand_tri();
        t_tri t;
        for (int k = 0; k < 3; k++)
            t.v[k] = mk_vert(rand_coord(), rand_coord(), rand_coord(), $urandom);
        return t;
    endfunction

    function automatic t_row mk_row(t_row_kind kind, t_vert a, b, c);
        t_row r;
        r.kind = kind;
        r.t.v[0] = a; r.t.v[1] = b; r.t.v[2] = c;
        return r;
    endfunction

    // Output side: random stall, compare each accepted vertex with the oldest expectation
    always @(negedge i_clk) i_stall = ($urandom_range(99) < stall_pct);

    always @(posedge i_clk) begin
        t_clip_vert exp_v;
        if (i_rst_n && o_valid && !i_stall) begin
            if (clip_verts_q.size() == 0) begin
                $display("%0t: unexpected vertex x=%h y=%h z=%h c=%h", $time,
                         o_out_x, o_out_y, o_out_z, o_out_color);
                fail_count++;
            end else begin
                exp_v = clip_verts_q.pop_front();
                if (o_out_x !== exp_v.x || o_out_y !== exp_v.y || o_out_z !== exp_v.z ||
                    o_out_color !== exp_v.color || o_end_of_triangle !== exp_v.eot ||
                    o_last !== exp_v.last) begin
                    $display("%0t: vertex mismatch expected x=%h y=%h z=%h c=%h eot=%b last=%b",
                             $time, exp_v.x, exp_v.y, exp_v.z, exp_v.color, exp_v.eot,
                             exp_v.last);
                    $display("%0t:                 actual   x=%h y=%h z=%h c=%h eot=%b last=%b",
                             $time, o_out_x, o_out_y, o_out_z, o_out_color,
                             o_end_of_triangle, o_last);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= IDLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        t_row rows [$];
        t_tri t;
        idle_pct = 0;
        stall_pct = 0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        {i_v0_x, i_v0_y, i_v0_z, i_v0_color} = '0;
        {i_v1_x, i_v1_y, i_v1_z, i_v1_color} = '0;
        {i_v2_x, i_v2_y, i_v2_z, i_v2_color} = '0;
        for (int k = 0; k < 6; k++) plane_regs[k] = '0;
        plane_regs[REG_NORMAL_Z] = ONE;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Writes past the register list must leave the reset plane (z >= 0 kept)
        cfg_write(IDX_SPARE_LO, 32'hdeadbeef);
        cfg_write(IDX_SPARE_HI, 32'h80000000);

        rows.push_back(mk_row(ROW_PASS, mk_vert(0, 0, 0, 32'h11223344),
            mk_vert(ONE, -ONE, 0, 32'h55667788), mk_vert(-5, 7, 0, 32'h99aabbcc)));
        rows.push_back(mk_row(ROW_PASS, mk_vert(CMAX, CMAX, CMAX, 32'hffffffff),
            mk_vert(CMIN, CMIN, CMAX, 32'h00000000), mk_vert(0, 0, 1, 32'h80000001)));
        rows.push_back(mk_row(ROW_DROP, mk_vert(0, 0, -1, 32'h1), mk_vert(3, 4, -ONE, 32'h2),
            mk_vert(CMAX, CMIN, -1, 32'h3)));
        rows.push_back(mk_row(ROW_DROP, mk_vert(CMIN, CMAX, CMIN, 32'hffffffff),
            mk_vert(CMAX, CMIN, CMIN, 32'h0), mk_vert(0, 0, CMIN, 32'h7fffffff)));
        rows.push_back(mk_row(ROW_PREDICT, mk_vert(CMAX, CMIN, CMAX, 32'ha0a0a0a0),
            mk_vert(CMIN, CMAX, CMIN, 32'hb1b1b1b1), mk_vert(CMIN, CMIN, CMIN, 32'hc2c2c2c2)));
        rows.push_back(mk_row(ROW_PREDICT, mk_vert(ONE, ONE, -ONE, 32'h01),
            mk_vert(2 * ONE, 0, 3 * ONE, 32'h02), mk_vert(-ONE, 5, -7, 32'h03)));
        rows.push_back(mk_row(ROW_PREDICT, mk_vert(100, 200, -300, 32'h0a),
            mk_vert(-100, 50, -1, 32'h0b), mk_vert(7, -9, 0, 32'h0c)));
        rows.push_back(mk_row(ROW_PREDICT, mk_vert(CMIN, 0, -ONE, 32'hdead0001),
            mk_vert(CMAX, ONE, ONE, 32'hdead0002), mk_vert(0, CMAX, 2 * ONE, 32'hdead0003)));
        rows.push_back(mk_row(ROW_PREDICT, mk_vert(ONE, 3, 5 * ONE, 32'h10),
            mk_vert(-ONE, 9, -3 * ONE, 32'h20), mk_vert(2, 2, 0, 32'h30)));
        rows.push_back(mk_row(ROW_PREDICT, mk_vert(CMAX, CMAX, 1, 32'h44),
            mk_vert(CMIN, CMIN, 0, 32'h55), mk_vert(CMAX, CMIN, CMIN, 32'h66)));
        rows.push_back(mk_row(ROW_PREDICT, mk_vert(3, 3, CMIN, 32'h77),
            mk_vert(-ONE, ONE, CMAX, 32'h88), mk_vert(CMIN, CMAX, CMAX, 32'h99)));
        foreach (rows[i]) send_tri(rows[i].t, rows[i].kind);
        i_valid = 1'b0;
        drain();

        // Zero normal: every distance is zero, so even a triangle below z = 0 passes
        set_plane(0, 0, 0, 0, 0, 0);
        send_tri(rows[2].t, ROW_PASS);
        send_tri(rows[3].t, ROW_PASS);
        i_valid = 1'b0;
        drain();

        for (int phase = 0; phase < 8; phase++) begin
            case (phase % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 58; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 58; end
                default: begin idle_pct = 16; stall_pct = 16; end
            endcase
            case (phase)
                0: set_plane(0, 0, ONE, 0, 0, 0);
                1: set_plane(CMAX, CMIN, CMAX, 0, 0, 0);
                2: set_plane($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
                3: set_plane(CMIN, CMAX, 0, CMAX, CMIN, CMIN);
                4: set_plane(0, 0, 0, $urandom, $urandom, $urandom);
                5: set_plane(rand_coord(), rand_coord(), rand_coord(),
                             rand_coord(), rand_coord(), rand_coord());
                6: set_plane(ONE, -ONE, ONE / 2, 0, ONE, -ONE);
                default: set_plane(-3, 5, -7, rand_coord(), rand_coord(), rand_coord());
            endcase
            for (int n = 0; n < 40; n++) begin
                t = rand_tri();
                send_tri(t, ROW_PREDICT);
            end
            i_valid = 1'b0;
            drain();
        end

        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule
